@@ rtl/clp_pkg.sv @@
`default_nettype none

package clp_pkg;

    localparam int MAX_DIGITS_DEFAULT = 12;

    localparam int CHAR_W   = 8;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int MAG_W    = 40;
    localparam int FRAC_W   = 4;
    localparam int LIM_W    = 72;
    localparam int POS_W    = 3;

    localparam logic [KIND_W-1:0] KIND_LAT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LONG = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [POS_W-1:0] LAT_PREFIX_LEN  = 3'd4;
    localparam logic [POS_W-1:0] LONG_PREFIX_LEN = 3'd5;

    localparam logic [1:0] MATCH_LAT  = 2'b01;
    localparam logic [1:0] MATCH_LONG = 2'b10;
    localparam logic [1:0] MATCH_BOTH = 2'b11;

    localparam int LAT_LIMIT  = 90;
    localparam int LONG_LIMIT = 180;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              fmt_err;
        logic              negative;
    } clp_flags_t;

    function automatic int acc_width(input int digits);
        logic [LIM_W-1:0] v;
        int               w;
        v = LIM_W'(1);
        for (int i = 0; i < digits; i++) begin
            v = v * LIM_W'(10);
        end
        v = v - LIM_W'(1);
        w = 1;
        for (int i = 0; i < LIM_W; i++) begin
            if (v[i]) begin
                w = i + 1;
            end
        end
        return w;
    endfunction

    function automatic logic [LIM_W-1:0] scaled_limit(input int limit, input int digits);
        logic [LIM_W-1:0] v;
        v = LIM_W'(limit);
        for (int i = 0; i < digits; i++) begin
            v = v * LIM_W'(10);
        end
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] lat_char(input logic [POS_W-1:0] pos);
        logic [CHAR_W-1:0] c;
        unique case (pos)
            3'd0: c = 8'h6C;
            3'd1: c = 8'h61;
            3'd2: c = 8'h74;
            3'd3: c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] long_char(input logic [POS_W-1:0] pos);
        logic [CHAR_W-1:0] c;
        unique case (pos)
            3'd0: c = 8'h6C;
            3'd1: c = 8'h6F;
            3'd2: c = 8'h6E;
            3'd3: c = 8'h67;
            3'd4: c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/clp_parser.sv @@
`default_nettype none

module clp_parser #(
    parameter int MAX_DIGITS = clp_pkg::MAX_DIGITS_DEFAULT,
    parameter int ACC_W      = clp_pkg::acc_width(clp_pkg::MAX_DIGITS_DEFAULT),
    parameter int CNT_W      = $clog2(clp_pkg::MAX_DIGITS_DEFAULT + 1)
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       advance,
    input  wire logic                       accept,
    input  wire logic [clp_pkg::CHAR_W-1:0] char_code,
    input  wire logic                       is_last,
    output logic                            cand_valid,
    output clp_pkg::clp_flags_t             cand_flags,
    output logic [ACC_W-1:0]                cand_acc,
    output logic [CNT_W-1:0]                cand_frac
);
    import clp_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]       match_reg, match_next;
    logic             in_num_reg, in_num_next;
    logic             first_reg, first_next;
    logic             minus_reg, minus_next;
    logic             dot_reg, dot_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] dcnt_reg, dcnt_next;
    logic [CNT_W-1:0] fcnt_reg, fcnt_next;
    logic             fmt_reg, fmt_next;

    logic             cand_valid_reg;
    clp_flags_t       cand_flags_reg, cand_flags_next;
    logic [ACC_W-1:0] cand_acc_reg;
    logic [CNT_W-1:0] cand_frac_reg;

    logic             is_digit;
    logic [3:0]       digit_val;
    logic             lat_ok;
    logic             long_ok;
    logic [1:0]       match_upd;
    logic [POS_W-1:0] pos_inc;

    assign is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign digit_val = 4'(char_code - CHAR_ZERO);
    assign lat_ok    = (pos_reg < LAT_PREFIX_LEN) && (char_code == lat_char(pos_reg));
    assign long_ok   = (pos_reg < LONG_PREFIX_LEN) && (char_code == long_char(pos_reg));
    assign match_upd = {match_reg[1] & long_ok, match_reg[0] & lat_ok};
    assign pos_inc   = pos_reg + POS_W'(1);

    always_comb begin
        pos_next    = pos_reg;
        match_next  = match_reg;
        in_num_next = in_num_reg;
        first_next  = first_reg;
        minus_next  = minus_reg;
        dot_next    = dot_reg;
        acc_next    = acc_reg;
        dcnt_next   = dcnt_reg;
        fcnt_next   = fcnt_reg;
        fmt_next    = fmt_reg;
        if (in_num_reg) begin
            first_next = 1'b0;
            if (!fmt_reg) begin
                if (char_code == CHAR_MINUS) begin
                    if (first_reg) begin
                        minus_next = 1'b1;
                    end else begin
                        fmt_next = 1'b1;
                    end
                end else if (is_digit) begin
                    if (dcnt_reg >= CNT_W'(MAX_DIGITS)) begin
                        fmt_next = 1'b1;
                    end else begin
                        acc_next  = (acc_reg << 3) + (acc_reg << 1) + ACC_W'(digit_val);
                        dcnt_next = dcnt_reg + CNT_W'(1);
                        if (dot_reg) begin
                            fcnt_next = fcnt_reg + CNT_W'(1);
                        end
                    end
                end else if (char_code == CHAR_DOT) begin
                    dot_next = 1'b1;
                end else begin
                    fmt_next = 1'b1;
                end
            end
        end else if (match_reg != 2'b00) begin
            pos_next   = pos_inc;
            match_next = match_upd;
            if (match_upd[0] && (pos_inc == LAT_PREFIX_LEN)) begin
                in_num_next = 1'b1;
                match_next  = MATCH_LAT;
            end else if (match_upd[1] && (pos_inc == LONG_PREFIX_LEN)) begin
                in_num_next = 1'b1;
                match_next  = MATCH_LONG;
            end
        end
    end

    always_comb begin
        cand_flags_next.kind     = KIND_NONE;
        cand_flags_next.fmt_err  = fmt_next;
        cand_flags_next.negative = minus_next;
        if (in_num_next) begin
            cand_flags_next.kind = (match_next == MATCH_LAT) ? KIND_LAT : KIND_LONG;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            match_reg  <= MATCH_BOTH;
            in_num_reg <= 1'b0;
            first_reg  <= 1'b1;
            minus_reg  <= 1'b0;
            dot_reg    <= 1'b0;
            acc_reg    <= '0;
            dcnt_reg   <= '0;
            fcnt_reg   <= '0;
            fmt_reg    <= 1'b0;
        end else if (accept) begin
            if (is_last) begin
                pos_reg    <= '0;
                match_reg  <= MATCH_BOTH;
                in_num_reg <= 1'b0;
                first_reg  <= 1'b1;
                minus_reg  <= 1'b0;
                dot_reg    <= 1'b0;
                acc_reg    <= '0;
                dcnt_reg   <= '0;
                fcnt_reg   <= '0;
                fmt_reg    <= 1'b0;
            end else begin
                pos_reg    <= pos_next;
                match_reg  <= match_next;
                in_num_reg <= in_num_next;
                first_reg  <= first_next;
                minus_reg  <= minus_next;
                dot_reg    <= dot_next;
                acc_reg    <= acc_next;
                dcnt_reg   <= dcnt_next;
                fcnt_reg   <= fcnt_next;
                fmt_reg    <= fmt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_valid_reg <= 1'b0;
        end else if (advance) begin
            cand_valid_reg <= accept && is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_last) begin
            cand_flags_reg <= cand_flags_next;
            cand_acc_reg   <= acc_next;
            cand_frac_reg  <= fcnt_next;
        end
    end

    assign cand_valid = cand_valid_reg;
    assign cand_flags = cand_flags_reg;
    assign cand_acc   = cand_acc_reg;
    assign cand_frac  = cand_frac_reg;

endmodule

`default_nettype wire

@@ rtl/clp_range.sv @@
`default_nettype none

module clp_range #(
    parameter int MAX_DIGITS = clp_pkg::MAX_DIGITS_DEFAULT,
    parameter int ACC_W      = clp_pkg::acc_width(clp_pkg::MAX_DIGITS_DEFAULT),
    parameter int CNT_W      = $clog2(clp_pkg::MAX_DIGITS_DEFAULT + 1)
) (
    input  wire clp_pkg::clp_flags_t         flags,
    input  wire logic [ACC_W-1:0]            acc,
    input  wire logic [CNT_W-1:0]            frac,
    output logic [clp_pkg::STATUS_W-1:0]     status,
    output logic [clp_pkg::MAG_W-1:0]        magnitude,
    output logic                             negative,
    output logic [clp_pkg::FRAC_W-1:0]       fraction_digits
);
    import clp_pkg::*;

    logic [LIM_W-1:0] lat_lim  [MAX_DIGITS+1];
    logic [LIM_W-1:0] long_lim [MAX_DIGITS+1];
    logic [LIM_W-1:0] acc_ext;
    logic [LIM_W-1:0] limit;
    logic [7:0]       frac_ext;

    for (genvar i = 0; i <= MAX_DIGITS; i++) begin : g_limits
        assign lat_lim[i]  = scaled_limit(LAT_LIMIT, i);
        assign long_lim[i] = scaled_limit(LONG_LIMIT, i);
    end

    assign acc_ext  = {{(LIM_W-ACC_W){1'b0}}, acc};
    assign frac_ext = {{(8-CNT_W){1'b0}}, frac};
    assign limit    = (flags.kind == KIND_LAT) ? lat_lim[frac] : long_lim[frac];

    always_comb begin
        status          = STATUS_OK;
        magnitude       = '0;
        negative        = 1'b0;
        fraction_digits = '0;
        if (flags.kind != KIND_NONE) begin
            if (flags.fmt_err) begin
                status = STATUS_BAD;
            end else begin
                status          = (acc_ext > limit) ? STATUS_RANGE : STATUS_OK;
                magnitude       = acc_ext[MAG_W-1:0];
                negative        = flags.negative;
                fraction_digits = frac_ext[FRAC_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/coordinate_line_parser.sv @@
// A result passes the parser's candidate register, then the output register that drives m_tvalid.
// Throughput: one character per cycle; the parse state and the range check are both
// registered stages, stalled together only while a result waits on m_tready.
// Reset: aresetn is synchronous and active low; it clears the parse state to the start of
// a line and drops both valid flags.
`default_nettype none

module coordinate_line_parser #(
    parameter int MAX_DIGITS = clp_pkg::MAX_DIGITS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // is_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [1:0] status, [41:2] magnitude, [42] negative,
                                        // [46:43] fraction_digits, [47] zero
    output logic [1:0]       m_tuser    // [1:0] coordinate_kind
);
    import clp_pkg::*;

    localparam int ACC_W = acc_width(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    logic             advance;
    logic             accept;
    logic             cand_valid;
    clp_flags_t       cand_flags;
    logic [ACC_W-1:0] cand_acc;
    logic [CNT_W-1:0] cand_frac;

    logic [STATUS_W-1:0] chk_status;
    logic [MAG_W-1:0]    chk_mag;
    logic                chk_neg;
    logic [FRAC_W-1:0]   chk_frac;

    logic                m_valid_reg;
    logic [KIND_W-1:0]   m_kind_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [MAG_W-1:0]    m_mag_reg;
    logic                m_neg_reg;
    logic [FRAC_W-1:0]   m_frac_reg;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    clp_parser #(
        .MAX_DIGITS (MAX_DIGITS),
        .ACC_W      (ACC_W),
        .CNT_W      (CNT_W)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .accept     (accept),
        .char_code  (s_tdata),
        .is_last    (s_tlast),
        .cand_valid (cand_valid),
        .cand_flags (cand_flags),
        .cand_acc   (cand_acc),
        .cand_frac  (cand_frac)
    );

    clp_range #(
        .MAX_DIGITS (MAX_DIGITS),
        .ACC_W      (ACC_W),
        .CNT_W      (CNT_W)
    ) u_range (
        .flags           (cand_flags),
        .acc             (cand_acc),
        .frac            (cand_frac),
        .status          (chk_status),
        .magnitude       (chk_mag),
        .negative        (chk_neg),
        .fraction_digits (chk_frac)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= cand_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && cand_valid) begin
            m_kind_reg   <= cand_flags.kind;
            m_status_reg <= chk_status;
            m_mag_reg    <= chk_mag;
            m_neg_reg    <= chk_neg;
            m_frac_reg   <= chk_frac;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_frac_reg, m_neg_reg, m_mag_reg, m_status_reg};
    assign m_tuser  = m_kind_reg;

endmodule

`default_nettype wire
